// ----- rtl/cmv_pkg.sv -----
// ----------------------------------------------------------------------------
// cmv_pkg: shared types and constants of the classifier majority vote
// Field widths, register codes, register reset values and the vote pick
// result that travels from the picker to the top level.
// ----------------------------------------------------------------------------
package cmv_pkg;

    localparam int CLS_W      = 3;   // class index and class register width
    localparam int VOTE_W     = 4;   // vote counter and vote output width
    localparam int LIMIT_W    = 4;   // low confidence limit width
    localparam int SLOT_W     = 4;   // window slot counter width
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_CONF_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_CLASS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_CLASS = 2'd2;

    localparam logic [LIMIT_W-1:0] LOW_CONF_LIMIT_RST = 4'd6;
    localparam logic [CLS_W-1:0]   NORMAL_CLASS_RST   = 3'd4;
    localparam logic [CLS_W-1:0]   FALLBACK_CLASS_RST = 3'd2;

    localparam logic [CLS_W-1:0]  FAULT_FIRST = 3'd1;
    localparam logic [CLS_W-1:0]  FAULT_LAST  = 3'd3;
    localparam logic [VOTE_W-1:0] VOTE_MAX    = 4'hF;

    typedef struct packed {
        logic [CLS_W-1:0]  win_class;
        logic [VOTE_W-1:0] win_votes;
    } pick_t;

endpackage

// ----- rtl/classifier_majority_vote.sv -----
// ----------------------------------------------------------------------------
// classifier_majority_vote: majority-vote smoothing of classifier decisions
// Flags fault classes at once and reports the modal class of every window
// of WINDOW decisions, with a low-confidence override of the normal class.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_class_index
//  m_        out        m_valid / m_ready    m_fault_now, m_window_done,
//                                            m_winner_class, m_winner_votes
//  cfg_      in         cfg_wr_en            cfg_index, cfg_wdata
//
// One beat in, one beat out; a beat is taken every cycle unless a held
// result stalls s_ready. The vote counters, the increment and the argmax
// precede the result register; a beat's result is ready the cycle after.
// s_ready stays high while the result register is empty or being drained.
// Reset clears the counters, the slot count and the registers to defaults.
// ----------------------------------------------------------------------------
module classifier_majority_vote
    import cmv_pkg::*;
#(
    parameter int WINDOW  = 10,
    parameter int CLASSES = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CLS_W-1:0]      s_class_index,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_fault_now,
    output logic                  m_window_done,
    output logic [CLS_W-1:0]      m_winner_class,
    output logic [VOTE_W-1:0]     m_winner_votes,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

    logic [LIMIT_W-1:0] low_conf_limit_reg;
    logic [CLS_W-1:0]   normal_class_reg;
    logic [CLS_W-1:0]   fallback_class_reg;

    logic [CLASSES-1:0][VOTE_W-1:0] counts_reg, counts_inc, counts_next;
    logic [SLOT_W-1:0]              slot_reg, slot_next;

    logic                  m_valid_reg;
    logic                  fault_reg, done_reg;
    logic [CLS_W-1:0]      win_class_reg;
    logic [VOTE_W-1:0]     win_votes_reg;

    logic  accept;
    logic  done;
    pick_t pick;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign done    = (slot_reg == LAST_SLOT);

    always_comb begin
        for (int i = 0; i < CLASSES; i++) begin
            counts_inc[i] = counts_reg[i];
            if (s_class_index == CLS_W'(i) && counts_reg[i] != VOTE_MAX) begin
                counts_inc[i] = counts_reg[i] + VOTE_W'(1);
            end
        end
    end

    cmv_vote_pick #(
        .CLASSES (CLASSES)
    ) u_pick (
        .counts         (counts_inc),
        .low_conf_limit (low_conf_limit_reg),
        .normal_class   (normal_class_reg),
        .fallback_class (fallback_class_reg),
        .pick           (pick)
    );

    always_comb begin
        counts_next = counts_reg;
        slot_next   = slot_reg;
        if (accept) begin
            if (done) begin
                counts_next = '0;
                slot_next   = '0;
            end else begin
                counts_next = counts_inc;
                slot_next   = slot_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counts_reg  <= '0;
            slot_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            counts_reg <= counts_next;
            slot_reg   <= slot_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; a window that is not done reports class 0 with no votes.
    always_ff @(posedge aclk) begin
        if (accept) begin
            fault_reg     <= (s_class_index >= FAULT_FIRST) && (s_class_index <= FAULT_LAST);
            done_reg      <= done;
            win_class_reg <= done ? pick.win_class : '0;
            win_votes_reg <= done ? pick.win_votes : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_conf_limit_reg <= LOW_CONF_LIMIT_RST;
            normal_class_reg   <= NORMAL_CLASS_RST;
            fallback_class_reg <= FALLBACK_CLASS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LOW_CONF_LIMIT: low_conf_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                REG_NORMAL_CLASS:   normal_class_reg   <= cfg_wdata[CLS_W-1:0];
                REG_FALLBACK_CLASS: fallback_class_reg <= cfg_wdata[CLS_W-1:0];
                default: ;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_fault_now    = fault_reg;
    assign m_window_done  = done_reg;
    assign m_winner_class = win_class_reg;
    assign m_winner_votes = win_votes_reg;

`ifndef SYNTH
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= LAST_SLOT)
        else $error("slot count ran past the window");

    a_window_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && done |=> slot_reg == '0 && counts_reg == '0 && m_window_done)
        else $error("finished window did not clear the counters");

    a_idle_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_window_done |-> m_winner_class == '0 && m_winner_votes == '0)
        else $error("winner fields set outside a finished window");

    a_votes_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_window_done |-> {1'b0, m_winner_votes} <= 5'(WINDOW))
        else $error("winner has more votes than window slots");
`endif

endmodule

// ----- rtl/cmv_vote_pick.sv -----
// ----------------------------------------------------------------------------
// cmv_vote_pick: winner selection over the vote counters
// Finds the class with the most votes, lowest index on a tie, and applies
// the low-confidence override of the normal class.
// ----------------------------------------------------------------------------
module cmv_vote_pick
    import cmv_pkg::*;
#(
    parameter int CLASSES = 5
) (
    input  logic [CLASSES-1:0][VOTE_W-1:0] counts,
    input  logic [LIMIT_W-1:0]             low_conf_limit,
    input  logic [CLS_W-1:0]               normal_class,
    input  logic [CLS_W-1:0]               fallback_class,
    output pick_t                          pick
);

    logic [CLS_W-1:0]  best_class;
    logic [VOTE_W-1:0] best_votes;

    // Strict compare keeps the earliest class on a tie.
    always_comb begin
        best_class = '0;
        best_votes = '0;
        for (int i = 0; i < CLASSES; i++) begin
            if (counts[i] > best_votes) begin
                best_votes = counts[i];
                best_class = CLS_W'(i);
            end
        end
    end

    always_comb begin
        pick.win_class = best_class;
        pick.win_votes = best_votes;
        if (best_class == normal_class && {1'b0, best_votes} <= {1'b0, low_conf_limit}) begin
            pick.win_class = fallback_class;
            pick.win_votes = '0;
        end
    end

endmodule

// ----- tb/cmv_vote_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmv_vote_checker: scoreboard of the classifier majority vote
// Watches the class and result channels and the register write port. It
// keeps its own vote tallies and register copies, works out the result of
// every accepted class beat and compares it with the next result beat.
// ----------------------------------------------------------------------------
module cmv_vote_checker
    import cmv_pkg::*;
#(
    parameter int WINDOW  = 10,
    parameter int CLASSES = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [CLS_W-1:0]      s_class_index,

    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_fault_now,
    input  logic                  m_window_done,
    input  logic [CLS_W-1:0]      m_winner_class,
    input  logic [VOTE_W-1:0]     m_winner_votes,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    output int                    fail_count,
    output int                    outstanding
);

    typedef struct packed {
        logic              fault_now;
        logic              window_done;
        logic [CLS_W-1:0]  winner_class;
        logic [VOTE_W-1:0] winner_votes;
    } vote_result_t;

    logic [VOTE_W-1:0]  tally [CLASSES];
    logic [SLOT_W-1:0]  slots_filled;
    logic [LIMIT_W-1:0] limit_reg;
    logic [CLS_W-1:0]   normal_reg;
    logic [CLS_W-1:0]   fallback_reg;
    vote_result_t       expected_votes [$];
    int                 errors = 0;

    // Counts one class decision and, when it closes the window, picks the winner.
    function automatic vote_result_t tally_class(input logic [CLS_W-1:0] cls);
        vote_result_t r;
        int           best;
        int           win;
        int           i;
        r           = '0;
        r.fault_now = (cls >= FAULT_FIRST) && (cls <= FAULT_LAST);
        if (int'(cls) < CLASSES) begin
            if (tally[cls] != VOTE_MAX) begin
                tally[cls] = tally[cls] + 1'b1;
            end
        end
        slots_filled = slots_filled + 1'b1;
        if (int'(slots_filled) >= WINDOW) begin
            best = 0;
            win  = 0;
            // Strictly greater keeps the lowest index on a tie.
            for (i = 0; i < CLASSES; i++) begin
                if (int'(tally[i]) > best) begin
                    best = int'(tally[i]);
                    win  = i;
                end
            end
            if (win == int'(normal_reg) && best <= int'(limit_reg)) begin
                win  = int'(fallback_reg);
                best = 0;
            end
            for (i = 0; i < CLASSES; i++) begin
                tally[i] = '0;
            end
            slots_filled   = '0;
            r.window_done  = 1'b1;
            r.winner_class = win[CLS_W-1:0];
            r.winner_votes = best[VOTE_W-1:0];
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        vote_result_t got;
        vote_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < CLASSES; i++) begin
                tally[i] = '0;
            end
            slots_filled = '0;
            limit_reg    = LOW_CONF_LIMIT_RST;
            normal_reg   = NORMAL_CLASS_RST;
            fallback_reg = FALLBACK_CLASS_RST;
            expected_votes.delete();
        end else begin
            // A result beat always belongs to an earlier class beat, so check first.
            if (m_valid && m_ready) begin
                got = '{m_fault_now, m_window_done, m_winner_class, m_winner_votes};
                if (expected_votes.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("%0t: result beat with nothing expected: fault=%0d done=%0d",
                                 $realtime, got.fault_now, got.window_done,
                                 " class=%0d votes=%0d", got.winner_class, got.winner_votes);
                    end
                end else begin
                    want = expected_votes.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%0t: result mismatch: expected fault=%0d done=%0d",
                                     $realtime, want.fault_now, want.window_done,
                                     " class=%0d votes=%0d, got fault=%0d done=%0d",
                                     want.winner_class, want.winner_votes,
                                     got.fault_now, got.window_done,
                                     " class=%0d votes=%0d",
                                     got.winner_class, got.winner_votes);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_votes.push_back(tally_class(s_class_index));
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_LOW_CONF_LIMIT: limit_reg    = cfg_wdata[LIMIT_W-1:0];
                    REG_NORMAL_CLASS:   normal_reg   = cfg_wdata[CLS_W-1:0];
                    REG_FALLBACK_CLASS: fallback_reg = cfg_wdata[CLS_W-1:0];
                    default: ;
                endcase
            end
        end
        fail_count  <= errors;
        outstanding <= expected_votes.size();
    end

endmodule

// ----- tb/tb_classifier_majority_vote.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_classifier_majority_vote: testbench of the classifier majority vote
// Feeds directed windows (weak normal winner, tie, invalid classes) and then
// biased random windows under several register settings, with random idle
// cycles on both channels. The checker module scores every result beat.
// ----------------------------------------------------------------------------
module tb_classifier_majority_vote;
    import cmv_pkg::*;

    localparam int WINDOW           = 10;
    localparam int CLASSES          = 5;
    localparam int IDLE_PCT         = 34;
    localparam int STALL_LIMIT      = 1000;
    localparam int PHASES           = 6;
    localparam int BLOCKS_PER_PHASE = 33;

    // Index past the last register; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [CLS_W-1:0]      s_class_index = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic                  m_fault_now;
    logic                  m_window_done;
    logic [CLS_W-1:0]      m_winner_class;
    logic [VOTE_W-1:0]     m_winner_votes;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  steady        = 1'b0;
    int                    fail_count;
    int                    outstanding;
    int                    quiet_cycles  = 0;

    // Window A: weak normal winner, window B: tie between faults plus invalid classes.
    logic [CLS_W-1:0] opening [20] = '{
        3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd1, 3'd2, 3'd3, 3'd0,
        3'd3, 3'd3, 3'd1, 3'd1, 3'd5, 3'd6, 3'd7, 3'd7, 3'd6, 3'd5
    };

    always #5 aclk = ~aclk;

    classifier_majority_vote #(
        .WINDOW  (WINDOW),
        .CLASSES (CLASSES)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_class_index  (s_class_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_fault_now    (m_fault_now),
        .m_window_done  (m_window_done),
        .m_winner_class (m_winner_class),
        .m_winner_votes (m_winner_votes),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    cmv_vote_checker #(
        .WINDOW  (WINDOW),
        .CLASSES (CLASSES)
    ) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_class_index  (s_class_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_fault_now    (m_fault_now),
        .m_window_done  (m_window_done),
        .m_winner_class (m_winner_class),
        .m_winner_votes (m_winner_votes),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .fail_count     (fail_count),
        .outstanding    (outstanding)
    );

    always @(negedge aclk) begin
        if (steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_classifier_majority_vote: FAIL");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat.
    // Valid is left high so back-to-back beats need no second assignment.
    task automatic send_class(input logic [CLS_W-1:0] cls);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_class_index <= cls;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
    endtask

    task automatic configure(input int phase);
        case (phase)
            1: begin
                // Normal class 0 makes an empty window fall back as well.
                write_reg(REG_LOW_CONF_LIMIT, 4'd0);
                write_reg(REG_NORMAL_CLASS,   4'd0);
                write_reg(REG_FALLBACK_CLASS, 4'd4);
            end
            2: begin
                // All-ones data masks to class 7, which no vote can reach.
                write_reg(REG_LOW_CONF_LIMIT, 4'hF);
                write_reg(REG_NORMAL_CLASS,   4'hF);
                write_reg(REG_FALLBACK_CLASS, 4'hF);
            end
            3: begin
                write_reg(REG_LOW_CONF_LIMIT, 4'd10);
                write_reg(REG_NORMAL_CLASS,   4'd4);
                write_reg(REG_FALLBACK_CLASS, 4'hF);
                write_reg(REG_UNMAPPED,       4'd0);
            end
            4: begin
                write_reg(REG_LOW_CONF_LIMIT, 4'd5);
                write_reg(REG_NORMAL_CLASS,   4'd2);
                write_reg(REG_FALLBACK_CLASS, 4'd0);
                write_reg(REG_UNMAPPED,       4'hF);
            end
            default: begin
                write_reg(REG_LOW_CONF_LIMIT, 4'($urandom_range(15)));
                write_reg(REG_NORMAL_CLASS,   4'($urandom_range(15)));
                write_reg(REG_FALLBACK_CLASS, 4'($urandom_range(15)));
                write_reg(REG_UNMAPPED,       4'($urandom_range(15)));
            end
        endcase
        cfg_wr_en <= 1'b0;
    endtask

    int phase;
    int blk;
    int n;
    int favored;
    int bias;

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (opening[k]) send_class(opening[k]);

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase != 0) begin
                drain();
                configure(phase);
            end
            // One quiet phase where neither side idles.
            steady <= (phase == 2);
            // A window of invalid classes only, so no class gets a vote.
            for (n = 0; n < WINDOW; n++) send_class(CLS_W'(5 + $urandom_range(2)));
            for (blk = 0; blk < BLOCKS_PER_PHASE; blk++) begin
                favored = $urandom_range(7);
                bias    = ($urandom_range(3) == 0) ? 100 : $urandom_range(100);
                for (n = 0; n < WINDOW; n++) begin
                    if ($urandom_range(99) < bias) begin
                        send_class(CLS_W'(favored));
                    end else begin
                        send_class(CLS_W'($urandom_range(7)));
                    end
                end
            end
        end

        drain();
        repeat (5) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_classifier_majority_vote: PASS");
        end else begin
            $display("tb_classifier_majority_vote: FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/cmv_pkg.sv
rtl/cmv_vote_pick.sv
rtl/classifier_majority_vote.sv
tb/cmv_vote_checker.sv
tb/tb_classifier_majority_vote.sv
